### rtl/adts_fs_pkg.sv
// Shared types, constants and the sample-rate table for the ADTS frame scanner.
// Used by every module under rtl but the divider; depends on nothing.
package adts_fs_pkg;

    // Field widths of the request channels.
    localparam int DATA_W   = 8;
    localparam int POS_W    = 13;
    localparam int LEN_W    = 13;
    localparam int HDR_W    = 48;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int OFFSET_W = 40;
    localparam int RATE_W   = 17;
    localparam int KBPS_W   = 16;
    localparam int MS_W     = 32;
    localparam int REASON_W = 2;
    localparam int IDX_W    = 4;

    // Header layout and scan positions.
    localparam logic [DATA_W-1:0] SYNC_BYTE  = 8'hFF;
    localparam logic [DATA_W-1:0] SYNC_MASK  = 8'hF6;
    localparam logic [DATA_W-1:0] SYNC_VALUE = 8'hF0;
    localparam logic [POS_W-1:0]  HDR_KEEP_POS = 13'd6;
    localparam logic [POS_W-1:0]  CHECK_POS    = 13'd7;
    localparam logic [POS_W-1:0]  BODY_POS     = 13'd8;
    localparam logic [POS_W-1:0]  NEXT_HDR_POS = 13'd1;
    localparam logic [LEN_W-1:0]  MIN_LEN      = 13'd7;
    localparam logic [LEN_W-1:0]  HDR_ONLY_LEN = 13'd8;
    localparam logic [IDX_W-1:0]  RATE_IDX_NONE = 4'd15;

    // Summary arithmetic.
    localparam int MS_PER_S = 1000;
    // Bits 8 (bytes to bits) and 2 (half-up rounding) folded into one shift.
    localparam int KBPS_SHIFT = 4;
    localparam logic [MS_W-1:0] MS_NO_RATE = 32'd1000;

    typedef enum logic {
        KIND_FRAME   = 1'b0,
        KIND_SUMMARY = 1'b1
    } result_kind_t;

    typedef enum logic [REASON_W-1:0] {
        END_CLEAN     = 2'd0,
        END_SYNC_LOST = 2'd1,
        END_TRUNCATED = 2'd2
    } end_reason_t;

    typedef enum logic {
        DIV_KBPS = 1'b0,
        DIV_MS   = 1'b1
    } div_op_t;

    typedef enum logic [2:0] {
        ST_SCAN,
        ST_MUL,
        ST_KBPS_GO,
        ST_KBPS_RUN,
        ST_MS_GO,
        ST_MS_RUN,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    mul_en;
        logic    div_start;
        div_op_t div_op;
        logic    store_kbps;
        logic    store_ms;
        logic    emit_summary;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic div_busy;
    } status_t;

    // Sampling-frequency index table; reserved indices give zero.
    function automatic logic [RATE_W-1:0] rate_hz(input logic [IDX_W-1:0] idx);
        logic [RATE_W-1:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            default: hz = '0;
        endcase
        return hz;
    endfunction

endpackage

### rtl/adts_fs_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the datapath for the summary figures; depends on nothing.
module adts_fs_divider #(
    parameter int WIDTH = 62
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH:0]   rem_shift;
    logic             fits;

    // One trial subtraction of the divisor from the shifted remainder.
    assign rem_shift = {rem_reg, quo_reg[WIDTH-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? WIDTH'(rem_shift - {1'b0, den_reg}) : rem_shift[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/adts_fs_datapath.sv
// Scan state, header decode, summary arithmetic and the result register.
// Depends on adts_fs_pkg and adts_fs_divider; driven by commands from adts_fs_ctrl.
module adts_fs_datapath #(
    parameter int SAMPLES_PER_FRAME = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  adts_fs_pkg::cmd_t                    cmd,
    output adts_fs_pkg::status_t                 status,
    input  logic [adts_fs_pkg::DATA_W-1:0]       s_data_byte,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_result_kind,
    output logic [adts_fs_pkg::OFFSET_W-1:0]     m_frame_offset,
    output logic [adts_fs_pkg::LEN_W-1:0]        m_frame_bytes,
    output logic [adts_fs_pkg::COUNT_W-1:0]      m_frame_count,
    output logic [adts_fs_pkg::TOTAL_W-1:0]      m_total_bytes,
    output logic [adts_fs_pkg::RATE_W-1:0]       m_sample_rate_hz,
    output logic [adts_fs_pkg::KBPS_W-1:0]       m_bitrate_kbps,
    output logic [adts_fs_pkg::MS_W-1:0]         m_length_ms,
    output logic [adts_fs_pkg::REASON_W-1:0]     m_end_reason,
    output logic                                 m_is_last
);

    localparam int POS_W    = adts_fs_pkg::POS_W;
    localparam int LEN_W    = adts_fs_pkg::LEN_W;
    localparam int HDR_W    = adts_fs_pkg::HDR_W;
    localparam int DATA_W   = adts_fs_pkg::DATA_W;
    localparam int COUNT_W  = adts_fs_pkg::COUNT_W;
    localparam int TOTAL_W  = adts_fs_pkg::TOTAL_W;
    localparam int OFFSET_W = adts_fs_pkg::OFFSET_W;
    localparam int RATE_W   = adts_fs_pkg::RATE_W;
    localparam int KBPS_W   = adts_fs_pkg::KBPS_W;
    localparam int MS_W     = adts_fs_pkg::MS_W;
    localparam int IDX_W    = adts_fs_pkg::IDX_W;
    localparam int REASON_W = adts_fs_pkg::REASON_W;

    // Samples per frame times milliseconds-per-second.
    localparam int MS_SCALE = adts_fs_pkg::MS_PER_S * SAMPLES_PER_FRAME;
    localparam int SCALE_W  = $clog2(MS_SCALE + 1);
    localparam int PROD_W   = COUNT_W + SCALE_W;
    localparam int Q_W      = TOTAL_W + RATE_W;
    localparam int KNUM_W   = Q_W + adts_fs_pkg::KBPS_SHIFT;
    localparam int DIV_W    = ((KNUM_W > PROD_W + 2) ? KNUM_W : PROD_W + 2) + 1;

    // Scan state.
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [HDR_W-1:0]    hdr_reg, hdr_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [COUNT_W-1:0]  frames_reg, frames_next;
    logic [TOTAL_W-1:0]  sum_reg, sum_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                stopped_reg, stopped_next;

    // Summary arithmetic.
    logic [PROD_W-1:0]   p_reg;
    logic [Q_W-1:0]      q_reg;
    logic [KBPS_W-1:0]   kbps_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic [DIV_W-1:0]    div_quotient;
    logic                div_busy;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic                kind_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [LEN_W-1:0]    out_bytes_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [RATE_W-1:0]   out_rate_reg;
    logic [KBPS_W-1:0]   out_kbps_reg;
    logic [MS_W-1:0]     out_ms_reg;
    logic [REASON_W-1:0] out_reason_reg;
    logic                out_last_reg;

    // Decode helpers.
    logic                sync_ok;
    logic [LEN_W-1:0]    hdr_len;
    logic [IDX_W-1:0]    hdr_idx;
    logic [POS_W:0]      pos_inc;
    logic [LEN_W-1:0]    finish_len;
    logic [OFFSET_W-1:0] offset_fin;
    logic [COUNT_W-1:0]  frames_fin;
    logic [TOTAL_W:0]    sum_wide;
    logic [TOTAL_W-1:0]  sum_sat;
    logic                scanning;
    logic                rec_load;
    logic [RATE_W-1:0]   rate_w;
    adts_fs_pkg::end_reason_t reason_w;

    // Header fields: sync word, frame length and sampling-frequency index.
    assign sync_ok = (hdr_reg[47:40] == adts_fs_pkg::SYNC_BYTE)
                  && ((hdr_reg[39:32] & adts_fs_pkg::SYNC_MASK) == adts_fs_pkg::SYNC_VALUE);
    assign hdr_len = {hdr_reg[17:16], hdr_reg[15:8], hdr_reg[7:5]};
    assign hdr_idx = hdr_reg[29:26];

    assign scanning   = cmd.accept && !stopped_reg;
    assign rec_load   = scanning && (pos_reg == adts_fs_pkg::CHECK_POS) && sync_ok;
    assign pos_inc    = {1'b0, pos_reg} + 1'b1;
    assign finish_len = (pos_reg == adts_fs_pkg::CHECK_POS) ? hdr_len : len_reg;
    assign offset_fin = offset_reg + OFFSET_W'(finish_len);
    assign frames_fin = (&frames_reg) ? frames_reg : frames_reg + 1'b1;
    assign sum_wide   = {1'b0, sum_reg} + (TOTAL_W + 1)'(hdr_len);
    assign sum_sat    = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
    assign rate_w     = adts_fs_pkg::rate_hz(idx_reg);

    // Per-byte walk through header and body.
    always_comb begin
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        len_next     = len_reg;
        frames_next  = frames_reg;
        sum_next     = sum_reg;
        offset_next  = offset_reg;
        idx_next     = idx_reg;
        stopped_next = stopped_reg;
        if (cmd.emit_summary) begin
            pos_next     = '0;
            hdr_next     = '0;
            len_next     = '0;
            frames_next  = '0;
            sum_next     = '0;
            offset_next  = '0;
            idx_next     = adts_fs_pkg::RATE_IDX_NONE;
            stopped_next = 1'b0;
        end else if (scanning) begin
            if (pos_reg < adts_fs_pkg::HDR_KEEP_POS) begin
                hdr_next = {hdr_reg[HDR_W-DATA_W-1:0], s_data_byte};
            end
            if (pos_reg == adts_fs_pkg::CHECK_POS) begin
                if (!sync_ok) begin
                    stopped_next = 1'b1;
                end else begin
                    len_next = hdr_len;
                    sum_next = sum_sat;
                    if (frames_reg == '0) begin
                        idx_next = hdr_idx;
                    end
                    if (hdr_len < adts_fs_pkg::MIN_LEN) begin
                        stopped_next = 1'b1;
                    end else if (hdr_len == adts_fs_pkg::MIN_LEN) begin
                        // The eighth byte already opens the next frame.
                        frames_next = frames_fin;
                        offset_next = offset_fin;
                        hdr_next    = HDR_W'(s_data_byte);
                        pos_next    = adts_fs_pkg::NEXT_HDR_POS;
                    end else if (hdr_len == adts_fs_pkg::HDR_ONLY_LEN) begin
                        frames_next = frames_fin;
                        offset_next = offset_fin;
                        pos_next    = '0;
                    end else begin
                        pos_next = adts_fs_pkg::BODY_POS;
                    end
                end
            end else if (pos_reg > adts_fs_pkg::CHECK_POS) begin
                if (pos_inc >= (POS_W + 1)'(len_reg)) begin
                    frames_next = frames_fin;
                    offset_next = offset_fin;
                    pos_next    = '0;
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end else begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            hdr_reg     <= '0;
            len_reg     <= '0;
            frames_reg  <= '0;
            sum_reg     <= '0;
            offset_reg  <= '0;
            idx_reg     <= adts_fs_pkg::RATE_IDX_NONE;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            len_reg     <= len_next;
            frames_reg  <= frames_next;
            sum_reg     <= sum_next;
            offset_reg  <= offset_next;
            idx_reg     <= idx_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Divider operands: half-up rounding is folded into numerator and divisor.
    always_comb begin
        if (cmd.div_op == adts_fs_pkg::DIV_KBPS) begin
            div_dividend = DIV_W'({q_reg, {adts_fs_pkg::KBPS_SHIFT{1'b0}}}) + DIV_W'(p_reg);
            div_divisor  = DIV_W'({p_reg, 1'b0});
        end else begin
            div_dividend = DIV_W'({p_reg, 1'b0}) + DIV_W'(rate_w);
            div_divisor  = DIV_W'({rate_w, 1'b0});
        end
    end

    adts_fs_divider #(
        .WIDTH (DIV_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Products and saturated quotients for the summary.
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            p_reg <= PROD_W'(frames_reg) * PROD_W'(MS_SCALE);
            q_reg <= Q_W'(sum_reg) * Q_W'(rate_w);
        end
        if (cmd.store_kbps) begin
            if (frames_reg == '0 || rate_w == '0) begin
                kbps_reg <= '0;
            end else if (|div_quotient[DIV_W-1:KBPS_W]) begin
                kbps_reg <= '1;
            end else begin
                kbps_reg <= div_quotient[KBPS_W-1:0];
            end
        end
        if (cmd.store_ms) begin
            if (rate_w == '0) begin
                ms_reg <= adts_fs_pkg::MS_NO_RATE;
            end else if (|div_quotient[DIV_W-1:MS_W]) begin
                ms_reg <= '1;
            end else begin
                ms_reg <= div_quotient[MS_W-1:0];
            end
        end
    end

    // End reason from the state left by the last byte.
    always_comb begin
        if (stopped_reg) begin
            reason_w = adts_fs_pkg::END_SYNC_LOST;
        end else if (pos_reg >= adts_fs_pkg::BODY_POS) begin
            reason_w = adts_fs_pkg::END_TRUNCATED;
        end else begin
            reason_w = adts_fs_pkg::END_CLEAN;
        end
    end

    // Result register: loaded by a frame record or the summary.
    assign m_valid_next = rec_load || cmd.emit_summary || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (rec_load) begin
            kind_reg       <= adts_fs_pkg::KIND_FRAME;
            out_offset_reg <= offset_reg;
            out_bytes_reg  <= hdr_len;
            out_count_reg  <= '0;
            out_total_reg  <= '0;
            out_rate_reg   <= '0;
            out_kbps_reg   <= '0;
            out_ms_reg     <= '0;
            out_reason_reg <= adts_fs_pkg::END_CLEAN;
            out_last_reg   <= !s_last_byte;
        end else if (cmd.emit_summary) begin
            kind_reg       <= adts_fs_pkg::KIND_SUMMARY;
            out_offset_reg <= '0;
            out_bytes_reg  <= '0;
            out_count_reg  <= frames_reg;
            out_total_reg  <= sum_reg;
            out_rate_reg   <= rate_w;
            out_kbps_reg   <= kbps_reg;
            out_ms_reg     <= ms_reg;
            out_reason_reg <= reason_w;
            out_last_reg   <= 1'b1;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.div_busy = div_busy;

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_frame_offset   = out_offset_reg;
    assign m_frame_bytes    = out_bytes_reg;
    assign m_frame_count    = out_count_reg;
    assign m_total_bytes    = out_total_reg;
    assign m_sample_rate_hz = out_rate_reg;
    assign m_bitrate_kbps   = out_kbps_reg;
    assign m_length_ms      = out_ms_reg;
    assign m_end_reason     = out_reason_reg;
    assign m_is_last        = out_last_reg;

endmodule

### rtl/adts_fs_ctrl.sv
// Controller state machine: byte acceptance and the end-of-stream summary sequence.
// Depends on adts_fs_pkg; drives adts_fs_datapath through cmd_t and reads status_t.
module adts_fs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last_byte,
    output logic                 s_ready,
    input  adts_fs_pkg::status_t status,
    output adts_fs_pkg::cmd_t    cmd
);

    adts_fs_pkg::ctrl_state_t state_reg, state_next;
    logic accept;

    assign s_ready = (state_reg == adts_fs_pkg::ST_SCAN) && status.out_free;
    assign accept  = s_valid && s_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            adts_fs_pkg::ST_SCAN: begin
                if (accept && s_last_byte) begin
                    state_next = adts_fs_pkg::ST_MUL;
                end
            end
            adts_fs_pkg::ST_MUL:     state_next = adts_fs_pkg::ST_KBPS_GO;
            adts_fs_pkg::ST_KBPS_GO: state_next = adts_fs_pkg::ST_KBPS_RUN;
            adts_fs_pkg::ST_KBPS_RUN: begin
                if (!status.div_busy) begin
                    state_next = adts_fs_pkg::ST_MS_GO;
                end
            end
            adts_fs_pkg::ST_MS_GO:   state_next = adts_fs_pkg::ST_MS_RUN;
            adts_fs_pkg::ST_MS_RUN: begin
                if (!status.div_busy) begin
                    state_next = adts_fs_pkg::ST_EMIT;
                end
            end
            adts_fs_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = adts_fs_pkg::ST_SCAN;
                end
            end
            default: state_next = adts_fs_pkg::ST_SCAN;
        endcase
    end

    // Commands.
    always_comb begin
        cmd              = '0;
        cmd.div_op       = adts_fs_pkg::DIV_KBPS;
        case (state_reg)
            adts_fs_pkg::ST_SCAN:     cmd.accept = accept;
            adts_fs_pkg::ST_MUL:      cmd.mul_en = 1'b1;
            adts_fs_pkg::ST_KBPS_GO:  cmd.div_start = 1'b1;
            adts_fs_pkg::ST_KBPS_RUN: cmd.store_kbps = !status.div_busy;
            adts_fs_pkg::ST_MS_GO: begin
                cmd.div_op    = adts_fs_pkg::DIV_MS;
                cmd.div_start = 1'b1;
            end
            adts_fs_pkg::ST_MS_RUN: begin
                cmd.div_op   = adts_fs_pkg::DIV_MS;
                cmd.store_ms = !status.div_busy;
            end
            adts_fs_pkg::ST_EMIT:     cmd.emit_summary = status.out_free;
            default:                  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= adts_fs_pkg::ST_SCAN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/adts_frame_scanner_top.sv
// ADTS frame scanner: one byte per request in, one frame record or summary per
// request out. A byte is taken whenever the result register is free. The byte
// marked last starts the summary, worked out by the shared bit-serial divider
// that runs once for the bitrate and once for the duration; no byte is taken
// until the summary has been loaded into the result register.
// Depends on adts_fs_pkg, adts_fs_ctrl and adts_fs_datapath.
module adts_frame_scanner_top #(
    parameter int SAMPLES_PER_FRAME = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [adts_fs_pkg::DATA_W-1:0]       s_data_byte,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_result_kind,
    output logic [adts_fs_pkg::OFFSET_W-1:0]     m_frame_offset,
    output logic [adts_fs_pkg::LEN_W-1:0]        m_frame_bytes,
    output logic [adts_fs_pkg::COUNT_W-1:0]      m_frame_count,
    output logic [adts_fs_pkg::TOTAL_W-1:0]      m_total_bytes,
    output logic [adts_fs_pkg::RATE_W-1:0]       m_sample_rate_hz,
    output logic [adts_fs_pkg::KBPS_W-1:0]       m_bitrate_kbps,
    output logic [adts_fs_pkg::MS_W-1:0]         m_length_ms,
    output logic [adts_fs_pkg::REASON_W-1:0]     m_end_reason,
    output logic                                 m_is_last
);

    adts_fs_pkg::cmd_t    cmd;
    adts_fs_pkg::status_t status;

    // Sequencing of byte requests and the summary.
    adts_fs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Scan state, arithmetic and result register.
    adts_fs_datapath #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_frame_offset   (m_frame_offset),
        .m_frame_bytes    (m_frame_bytes),
        .m_frame_count    (m_frame_count),
        .m_total_bytes    (m_total_bytes),
        .m_sample_rate_hz (m_sample_rate_hz),
        .m_bitrate_kbps   (m_bitrate_kbps),
        .m_length_ms      (m_length_ms),
        .m_end_reason     (m_end_reason),
        .m_is_last        (m_is_last)
    );

endmodule

### tb/sv/adts_scan_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the ADTS frame scanner: follows both request channels, predicts the
// frame records and stream summaries, and compares each result field by field.
// Depends on adts_fs_pkg.
module adts_scan_checker
    import adts_fs_pkg::*;
#(
    parameter int SAMPLES_PER_FRAME = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [DATA_W-1:0]     s_data_byte,
    input  logic                  s_last_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_result_kind,
    input  logic [OFFSET_W-1:0]   m_frame_offset,
    input  logic [LEN_W-1:0]      m_frame_bytes,
    input  logic [COUNT_W-1:0]    m_frame_count,
    input  logic [TOTAL_W-1:0]    m_total_bytes,
    input  logic [RATE_W-1:0]     m_sample_rate_hz,
    input  logic [KBPS_W-1:0]     m_bitrate_kbps,
    input  logic [MS_W-1:0]       m_length_ms,
    input  logic [REASON_W-1:0]   m_end_reason,
    input  logic                  m_is_last,
    output int                    fail_count,
    output int                    pending,
    output int                    records_seen,
    output int                    summaries_seen
);

    // Sampling frequency for each header index; reserved indices give zero.
    localparam int unsigned HZ_TABLE [16] = '{
        96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050,
        16000, 12000, 11025, 8000, 0, 0, 0, 0
    };

    typedef struct packed {
        result_kind_t          kind;
        logic [OFFSET_W-1:0]   offset;
        logic [LEN_W-1:0]      length;
        logic [COUNT_W-1:0]    count;
        logic [TOTAL_W-1:0]    total;
        logic [RATE_W-1:0]     rate;
        logic [KBPS_W-1:0]     kbps;
        logic [MS_W-1:0]       ms;
        end_reason_t           reason;
        logic                  last;
    } scan_result_t;

    // Results predicted but not yet seen on the result channel.
    scan_result_t expected_q[$];

    // Predicted scanner state.
    logic [POS_W-1:0]    pos_in_frame;
    logic [HDR_W-1:0]    hdr_shift;
    logic [LEN_W-1:0]    frame_len;
    logic [COUNT_W-1:0]  frames_done;
    logic [TOTAL_W-1:0]  sum_bytes;
    logic [OFFSET_W-1:0] frame_start;
    logic [IDX_W-1:0]    rate_sel;
    logic                halted;

    task automatic clear_scan();
        pos_in_frame = '0;
        hdr_shift = '0;
        frame_len = '0;
        frames_done = '0;
        sum_bytes = '0;
        frame_start = '0;
        rate_sel = RATE_IDX_NONE;
        halted = 1'b0;
    endtask

    // A frame is complete: count it and move the offset past it.
    task automatic close_frame(input logic [LEN_W-1:0] len);
        if (frames_done != '1)
            frames_done = frames_done + 1'b1;
        frame_start = frame_start + OFFSET_W'(len);
        pos_in_frame = '0;
    endtask

    // Advance the predicted scanner by one byte and queue the results it causes.
    task automatic take_byte(input logic [DATA_W-1:0] b, input logic fin);
        scan_result_t out_q[$];
        scan_result_t r;
        logic [LEN_W-1:0] len;
        logic [TOTAL_W:0] sum_wide;
        logic [63:0] hz, num, den, kbps, ms;
        if (!halted) begin
            if (pos_in_frame < HDR_KEEP_POS)
                hdr_shift = {hdr_shift[HDR_W-9:0], b};
            if (pos_in_frame == CHECK_POS) begin
                // Eighth byte of the frame: check sync and pull out the length.
                if (hdr_shift[47:40] != SYNC_BYTE ||
                    (hdr_shift[39:32] & SYNC_MASK) != SYNC_VALUE) begin
                    halted = 1'b1;
                end else begin
                    len = {hdr_shift[17:16], hdr_shift[15:8], hdr_shift[7:5]};
                    frame_len = len;
                    if (frames_done == '0)
                        rate_sel = hdr_shift[29:26];
                    r = '0;
                    r.kind = KIND_FRAME;
                    r.offset = frame_start;
                    r.length = len;
                    out_q.push_back(r);
                    sum_wide = {1'b0, sum_bytes} + (TOTAL_W+1)'(len);
                    sum_bytes = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                    if (len < MIN_LEN) begin
                        halted = 1'b1;
                    end else if (len == MIN_LEN) begin
                        // This byte already belongs to the next frame.
                        close_frame(len);
                        hdr_shift = HDR_W'(b);
                        pos_in_frame = NEXT_HDR_POS;
                    end else if (len == HDR_ONLY_LEN) begin
                        close_frame(len);
                    end else begin
                        pos_in_frame = BODY_POS;
                    end
                end
            end else if (pos_in_frame > CHECK_POS) begin
                if ({1'b0, pos_in_frame} + 14'd1 >= {1'b0, frame_len})
                    close_frame(frame_len);
                else
                    pos_in_frame = pos_in_frame + 1'b1;
            end else begin
                pos_in_frame = pos_in_frame + 1'b1;
            end
        end

        // End of stream: build the summary and start over.
        if (fin) begin
            r = '0;
            r.kind = KIND_SUMMARY;
            if (halted)
                r.reason = END_SYNC_LOST;
            else if (pos_in_frame >= BODY_POS)
                r.reason = END_TRUNCATED;
            else
                r.reason = END_CLEAN;
            hz = 64'(HZ_TABLE[rate_sel]);
            kbps = 64'd0;
            ms = 64'(MS_NO_RATE);
            if (frames_done != '0 && hz != 64'd0) begin
                num = 64'd8 * 64'(sum_bytes) * hz;
                den = 64'(frames_done) * 64'd1000 * 64'(SAMPLES_PER_FRAME);
                kbps = (64'd2 * num + den) / (64'd2 * den);
                if (kbps > 64'hFFFF)
                    kbps = 64'hFFFF;
            end
            if (hz != 64'd0) begin
                num = 64'(frames_done) * 64'(SAMPLES_PER_FRAME) * 64'd1000;
                ms = (64'd2 * num + hz) / (64'd2 * hz);
                if (ms > 64'hFFFF_FFFF)
                    ms = 64'hFFFF_FFFF;
            end
            r.count = frames_done;
            r.total = sum_bytes;
            r.rate = hz[RATE_W-1:0];
            r.kbps = kbps[KBPS_W-1:0];
            r.ms = ms[MS_W-1:0];
            out_q.push_back(r);
            clear_scan();
        end

        if (out_q.size() > 0) begin
            out_q[out_q.size()-1].last = 1'b1;
            foreach (out_q[k])
                expected_q.push_back(out_q[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Predict on every accepted byte, then compare every accepted result.
    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            clear_scan();
            expected_q.delete();
            fail_count = 0;
            records_seen = 0;
            summaries_seen = 0;
        end else begin
            if (s_valid && s_ready)
                take_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result_kind: expected no result, got %0d", m_result_kind);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("result_kind", 64'(want.kind), 64'(m_result_kind));
                    check_field("frame_offset", 64'(want.offset), 64'(m_frame_offset));
                    check_field("frame_bytes", 64'(want.length), 64'(m_frame_bytes));
                    check_field("frame_count", 64'(want.count), 64'(m_frame_count));
                    check_field("total_bytes", 64'(want.total), 64'(m_total_bytes));
                    check_field("sample_rate_hz", 64'(want.rate), 64'(m_sample_rate_hz));
                    check_field("bitrate_kbps", 64'(want.kbps), 64'(m_bitrate_kbps));
                    check_field("length_ms", 64'(want.ms), 64'(m_length_ms));
                    check_field("end_reason", 64'(want.reason), 64'(m_end_reason));
                    check_field("is_last", 64'(want.last), 64'(m_is_last));
                    if (want.kind == KIND_SUMMARY)
                        summaries_seen++;
                    else
                        records_seen++;
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the ADTS frame scanner testbench: clock, reset, byte streams, back-pressure
// and the verdict. Depends on adts_fs_pkg, adts_frame_scanner_top and adts_scan_checker.
module testbench;
    import adts_fs_pkg::*;

    localparam int SPF          = 1024;
    localparam int STREAM_BYTES = 850;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_byte = '0;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_result_kind;
    logic [OFFSET_W-1:0]   m_frame_offset;
    logic [LEN_W-1:0]      m_frame_bytes;
    logic [COUNT_W-1:0]    m_frame_count;
    logic [TOTAL_W-1:0]    m_total_bytes;
    logic [RATE_W-1:0]     m_sample_rate_hz;
    logic [KBPS_W-1:0]     m_bitrate_kbps;
    logic [MS_W-1:0]       m_length_ms;
    logic [REASON_W-1:0]   m_end_reason;
    logic                  m_is_last;

    int fail_count, pending, records_seen, summaries_seen;
    int bytes_sent = 0;
    int streams_sent = 0;
    int s_steady = 0;
    int m_hold = 0;
    int m_steady = 0;
    int idle_cycles = 0;

    // Bytes of the stream being built, sent in order with the last one marked.
    logic [DATA_W-1:0] stream_q[$];

    always #10 aclk = ~aclk;

    adts_frame_scanner_top #(
        .SAMPLES_PER_FRAME(SPF)
    ) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_kind(m_result_kind), .m_frame_offset(m_frame_offset),
        .m_frame_bytes(m_frame_bytes), .m_frame_count(m_frame_count),
        .m_total_bytes(m_total_bytes), .m_sample_rate_hz(m_sample_rate_hz),
        .m_bitrate_kbps(m_bitrate_kbps), .m_length_ms(m_length_ms),
        .m_end_reason(m_end_reason), .m_is_last(m_is_last)
    );

    adts_scan_checker #(
        .SAMPLES_PER_FRAME(SPF)
    ) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_kind(m_result_kind), .m_frame_offset(m_frame_offset),
        .m_frame_bytes(m_frame_bytes), .m_frame_count(m_frame_count),
        .m_total_bytes(m_total_bytes), .m_sample_rate_hz(m_sample_rate_hz),
        .m_bitrate_kbps(m_bitrate_kbps), .m_length_ms(m_length_ms),
        .m_end_reason(m_end_reason), .m_is_last(m_is_last),
        .fail_count(fail_count), .pending(pending),
        .records_seen(records_seen), .summaries_seen(summaries_seen)
    );

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Result side back-pressure, with long stretches of steady readiness.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_hold > 0) begin
            m_ready <= 1'b0;
            m_hold--;
        end else begin
            m_ready <= 1'b1;
            if (m_steady > 0)
                m_steady--;
            else if ($urandom_range(0, 99) == 0)
                m_steady = $urandom_range(30, 200);
            else if ($urandom_range(0, 3) == 0)
                m_hold = pick_delay();
        end
    end

    // Watchdog: too long without any request moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("adts_frame_scanner_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one byte, with an optional gap first, and wait for it to be taken.
    task automatic send_byte(input logic [DATA_W-1:0] d, input logic fin);
        int gap;
        gap = 0;
        if (s_steady > 0)
            s_steady--;
        else if ($urandom_range(0, 49) == 0)
            s_steady = $urandom_range(20, 150);
        else
            gap = pick_delay();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= fin;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            stream_q.push_back(DATA_W'($urandom));
    endtask

    // First seven bytes of a frame header; the free header bits are random.
    task automatic push_header(input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] idx,
                               input bit sync_ok);
        logic [DATA_W-1:0] b0, b1;
        b0 = SYNC_BYTE;
        b1 = SYNC_VALUE | (8'($urandom_range(0, 1)) << 3) | 8'($urandom_range(0, 1));
        if (!sync_ok) begin
            if ($urandom_range(0, 1) == 1) begin
                do b0 = DATA_W'($urandom); while (b0 == SYNC_BYTE);
            end else begin
                do b1 = DATA_W'($urandom); while ((b1 & SYNC_MASK) == SYNC_VALUE);
            end
        end
        stream_q.push_back(b0);
        stream_q.push_back(b1);
        stream_q.push_back({2'($urandom), idx, 2'($urandom)});
        stream_q.push_back({6'($urandom), len[12:11]});
        stream_q.push_back(len[10:3]);
        stream_q.push_back({len[2:0], 5'($urandom)});
        stream_q.push_back(DATA_W'($urandom));
    endtask

    // A stream of mostly well-formed frames, ending cleanly, cut short or broken.
    task automatic build_random_stream();
        int n_frames, pick;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        bit done;
        stream_q.delete();
        n_frames = $urandom_range(0, 6);
        done = 0;
        for (int i = 0; i < n_frames && !done; i++) begin
            if ($urandom_range(0, 9) < 8)
                idx = IDX_W'($urandom_range(0, 11));
            else
                idx = IDX_W'($urandom_range(12, 15));
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // Broken sync word, followed by bytes the scanner ignores.
                push_header(LEN_W'($urandom), idx, 0);
                push_random($urandom_range(1, 6));
                done = 1;
            end else if (pick < 9) begin
                // Length below the header size stops the scan.
                push_header(LEN_W'($urandom_range(0, 6)), idx, 1);
                push_random($urandom_range(1, 6));
                done = 1;
            end else if (pick < 14) begin
                // Long frame that the stream ends inside.
                push_header(LEN_W'($urandom_range(64, 8191)), idx, 1);
                push_random($urandom_range(1, 12));
                done = 1;
            end else begin
                if (pick < 26)
                    len = MIN_LEN;
                else if (pick < 36)
                    len = HDR_ONLY_LEN;
                else
                    len = LEN_W'($urandom_range(9, 40));
                push_header(len, idx, 1);
                if (len != MIN_LEN) begin
                    if ($urandom_range(0, 19) == 0) begin
                        push_random($urandom_range(1, len - 1));
                        done = 1;
                    end else begin
                        push_random(len - 7);
                    end
                end
            end
        end

        // Tail: a clean end, stray bytes, or a header with at most one byte after it.
        if (!done) begin
            pick = $urandom_range(0, 3);
            if (pick == 1) begin
                push_random($urandom_range(1, 7));
            end else if (pick == 2) begin
                push_header(LEN_W'($urandom_range(9, 40)), IDX_W'($urandom_range(0, 11)), 1);
                push_random($urandom_range(0, 1));
            end
        end
        if (stream_q.size() == 0)
            push_random(1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // A single byte: no frame at all, so no rate.
        stream_q.delete();
        stream_q.push_back(SYNC_BYTE);
        send_stream();

        // Seven-byte frame, header-only frame, then a maximum length frame cut short.
        stream_q.delete();
        push_header(MIN_LEN, IDX_W'(4), 1);
        push_header(HDR_ONLY_LEN, IDX_W'(11), 1);
        push_random(1);
        push_header(LEN_W'(13'h1FFF), IDX_W'(0), 1);
        push_random(2);
        send_stream();

        while (bytes_sent < STREAM_BYTES) begin
            build_random_stream();
            send_stream();
        end
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d streams.", bytes_sent, streams_sent);
        $display("Checked %0d frame records and %0d stream summaries.",
                 records_seen, summaries_seen);
        if (fail_count == 0 && pending == 0)
            $display("adts_frame_scanner_top test passed");
        else
            $display("adts_frame_scanner_top test failed");
        $finish;
    end

endmodule
